// File: rtl/iusb_pkg.sv
// Shared types, codes and unit-mapping tables for the issue scoreboard.
`timescale 1ns / 1ps

package iusb_pkg;

   localparam int UNIT_COUNT  = 10;
   localparam int GROUP_COUNT = 23;

   typedef logic [3:0] unit_type;
   typedef logic [3:0] count_type;

   // Answer codes and named unit codes
   localparam unit_type ANS_FULL      = 4'd10;
   localparam unit_type ANS_NOT_READY = 4'd11;
   localparam unit_type ANS_UNDEFINED = 4'd12;
   localparam unit_type NO_UNIT       = 4'd15;
   localparam unit_type SHARED_UNIT   = 4'd1;
   localparam unit_type ANS_CLEAR     = 4'd0;

   localparam count_type COUNT_MAX = 4'd15;

   // Processor codes
   localparam logic [1:0] PROC_CORE = 2'd0;
   localparam logic [1:0] PROC_CP1  = 2'd1;
   localparam logic [1:0] PROC_CP2  = 2'd2;

   // CSR indexes
   localparam logic [1:0] CSR_CORE_LIMIT = 2'd0;
   localparam logic [1:0] CSR_CP1_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_CP2_LIMIT  = 2'd2;

   localparam logic [4:0] GROUP_RISC_ALU = 5'd0;

   typedef enum logic [1:0] {
      MODE_CHECK = 2'd0,
      MODE_LOCK  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // One registered command beat
   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic [4:0] kind;
      logic       hilo_mult;
      logic [1:0] processor;
   } cmd_type;

   // Per-processor issue counts
   typedef struct packed {
      count_type core;
      count_type cp1;
      count_type cp2;
   } issue_type;

   // Preferred unit per instruction group
   function automatic unit_type first_unit(input logic [4:0] kind);
      unit_type u;
      case (kind)
         5'd0:                                 u = 4'd0;
         5'd1, 5'd2, 5'd3, 5'd4:               u = 4'd3;
         5'd5, 5'd6, 5'd7:                     u = 4'd2;
         5'd8:                                 u = 4'd4;
         5'd9, 5'd10:                          u = 4'd5;
         5'd11:                                u = 4'd6;
         5'd12:                                u = 4'd7;
         5'd13:                                u = 4'd8;
         5'd14, 5'd15, 5'd16:                  u = 4'd9;
         5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22: u = 4'd1;
         default:                              u = NO_UNIT;
      endcase
      return u;
   endfunction

   // Fallback unit: only risc alu and risc ls fall back to the shared unit
   function automatic unit_type second_unit(input logic [4:0] kind);
      unit_type u;
      case (kind)
         5'd0, 5'd5: u = SHARED_UNIT;
         default:    u = NO_UNIT;
      endcase
      return u;
   endfunction

   function automatic count_type sat_inc(input count_type c);
      return (c == COUNT_MAX) ? COUNT_MAX : count_type'(c + 4'd1);
   endfunction

endpackage

// File: rtl/iusb_check.sv
// Check path: issue-limit test and group-to-free-unit selection.
`timescale 1ns / 1ps

module iusb_check import iusb_pkg::*; (
   input  logic [4:0]            kind,
   input  logic                  hilo_mult,
   input  logic [1:0]            processor,
   input  logic [UNIT_COUNT-1:0] busy_mask,
   input  issue_type             issued,
   input  issue_type             limits,
   output unit_type              answer
);

   logic     proc_ok;
   count_type used;
   count_type limit;
   unit_type unit_a;
   unit_type unit_b;
   logic     free_a;
   logic     free_b;

   always_comb begin
      proc_ok = 1'b1;
      case (processor)
         PROC_CORE: begin
            used  = issued.core;
            limit = limits.core;
         end
         PROC_CP1: begin
            used  = issued.cp1;
            limit = limits.cp1;
         end
         PROC_CP2: begin
            used  = issued.cp2;
            limit = limits.cp2;
         end
         default: begin
            proc_ok = 1'b0;
            used    = '0;
            limit   = '0;
         end
      endcase
   end

   always_comb begin
      unit_a = first_unit(kind);
      unit_b = second_unit(kind);
      // mfhi/mflo/mult run only on the shared unit
      if (kind == GROUP_RISC_ALU && hilo_mult) begin
         unit_a = SHARED_UNIT;
         unit_b = NO_UNIT;
      end
      free_a = (unit_a < unit_type'(UNIT_COUNT)) ? !busy_mask[unit_a] : 1'b0;
      free_b = (unit_b < unit_type'(UNIT_COUNT)) ? !busy_mask[unit_b] : 1'b0;
   end

   always_comb begin
      if (!proc_ok)                              answer = ANS_UNDEFINED;
      else if (used >= limit)                    answer = ANS_FULL;
      else if (kind >= 5'(GROUP_COUNT))          answer = ANS_UNDEFINED;
      else if (free_a)                           answer = unit_a;
      else if (free_b)                           answer = unit_b;
      else                                       answer = ANS_NOT_READY;
   end

endmodule

// File: rtl/iusb_state.sv
// Scoreboard state: busy mask, issue counts and lock total with lock/clear update.
`timescale 1ns / 1ps

module iusb_state import iusb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  issue_type             limits,
   output unit_type              answer,
   output logic [UNIT_COUNT-1:0] busy_next,
   output logic [31:0]           total_next
);

   logic [UNIT_COUNT-1:0] busy_ff;
   logic [UNIT_COUNT-1:0] busy_in;
   issue_type             issued_ff;
   issue_type             issued_in;
   logic [31:0]           total_ff;
   logic [31:0]           total_in;
   unit_type              check_answer;
   logic                  lock_ok;

   iusb_check u_check (
      .kind      (cmd.kind),
      .hilo_mult (cmd.hilo_mult),
      .processor (cmd.processor),
      .busy_mask (busy_ff),
      .issued    (issued_ff),
      .limits    (limits),
      .answer    (check_answer)
   );

   always_comb begin
      busy_in   = busy_ff;
      issued_in = issued_ff;
      total_in  = total_ff;
      answer    = ANS_UNDEFINED;
      lock_ok   = (cmd.kind < 5'(UNIT_COUNT)) && (cmd.processor <= PROC_CP2);
      case (cmd.mode)
         MODE_CHECK: begin
            answer = check_answer;
         end
         MODE_LOCK: begin
            if (lock_ok) begin
               answer = cmd.kind[3:0];
               busy_in[cmd.kind[3:0]] = 1'b1;
               total_in = total_ff + 32'd1;
               case (cmd.processor)
                  PROC_CORE: issued_in.core = sat_inc(issued_ff.core);
                  PROC_CP1:  issued_in.cp1  = sat_inc(issued_ff.cp1);
                  default:   issued_in.cp2  = sat_inc(issued_ff.cp2);
               endcase
            end
         end
         MODE_CLEAR: begin
            answer    = ANS_CLEAR;
            busy_in   = '0;
            issued_in = '0;
         end
         default: begin
            answer = ANS_UNDEFINED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= '0;
         issued_ff <= '0;
         total_ff  <= '0;
      end else if (cmd.valid) begin
         busy_ff   <= busy_in;
         issued_ff <= issued_in;
         total_ff  <= total_in;
      end
   end

   assign busy_next  = busy_in;
   assign total_next = total_in;

endmodule

// File: rtl/issue_unit_scoreboard_core.sv
// Top level of the issue scoreboard: command register, CSRs and result register.
`timescale 1ns / 1ps

// Issue scoreboard. Each command beat (check, lock or clear) is captured in
// an input register, resolved against the busy mask and issue counts in
// combinational logic, and returned through a result register: a taken
// start sets cmd_ff, then rsp_valid_ff. busy never rises, so a command can
// be issued every cycle and one result leaves every cycle; state written by a
// lock or clear is seen by the very next command. The receiver cannot stall:
// each result is on the rsp_ ports for exactly one cycle. rsp_busy_units and
// rsp_total_locked show state after the command. The three issue limits are
// written through the csr_ port, which is always ready; write them only when
// no command is in flight.
module issue_unit_scoreboard_core import iusb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // command
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_kind,
   input  logic        req_hilo_mult,
   input  logic [1:0]  req_processor,
   // result
   output logic        rsp_valid,
   output logic [3:0]  rsp_answer,
   output logic [9:0]  rsp_busy_units,
   output logic [31:0] rsp_total_locked,
   // CSR writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   cmd_type               cmd_ff;
   cmd_type               cmd_in;
   issue_type             limits_ff;
   unit_type              answer_in;
   logic [UNIT_COUNT-1:0] busy_in;
   logic [31:0]           total_in;
   logic                  rsp_valid_ff;
   unit_type              answer_ff;
   logic [UNIT_COUNT-1:0] busy_units_ff;
   logic [31:0]           total_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Command register
   always_comb begin
      cmd_in.valid     = start && !busy;
      cmd_in.mode      = req_mode;
      cmd_in.kind      = req_kind;
      cmd_in.hilo_mult = req_hilo_mult;
      cmd_in.processor = req_processor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid <= 1'b0;
      end else begin
         cmd_ff.valid <= cmd_in.valid;
      end
      cmd_ff.mode      <= cmd_in.mode;
      cmd_ff.kind      <= cmd_in.kind;
      cmd_ff.hilo_mult <= cmd_in.hilo_mult;
      cmd_ff.processor <= cmd_in.processor;
   end

   // Issue limits; writes to unused index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.core <= 4'd2;
         limits_ff.cp1  <= 4'd1;
         limits_ff.cp2  <= 4'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CORE_LIMIT: limits_ff.core <= csr_data;
            CSR_CP1_LIMIT:  limits_ff.cp1  <= csr_data;
            CSR_CP2_LIMIT:  limits_ff.cp2  <= csr_data;
            default: ;
         endcase
      end
   end

   iusb_state u_state (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_ff),
      .limits     (limits_ff),
      .answer     (answer_in),
      .busy_next  (busy_in),
      .total_next (total_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd_ff.valid;
      end
      answer_ff     <= answer_in;
      busy_units_ff <= busy_in;
      total_ff      <= total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer       = answer_ff;
   assign rsp_busy_units   = busy_units_ff;
   assign rsp_total_locked = total_ff;

   // Every accepted command beat yields exactly one result beat, via cmd_ff and rsp_valid_ff
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("result beat missing for accepted command");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!start && !$past(reset)) |=> ##1 !rsp_valid)
      else $error("result beat without command");

   // Answer codes stop at undefined
   a_answer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_answer <= ANS_UNDEFINED))
      else $error("answer code out of range");

   // Lock total only ever steps by one between results
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && !$past(reset, 2) && !$past(reset))
      |-> (rsp_total_locked == $past(rsp_total_locked)
           || rsp_total_locked == $past(rsp_total_locked) + 32'd1))
      else $error("lock total jumped");

endmodule

// File: verif/issue_unit_scoreboard_core_checker.sv
// Checker for the issue scoreboard: predicts each answer beat and compares it with the rsp_ port.
`timescale 1ns / 1ps

module issue_unit_scoreboard_core_checker import iusb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_kind,
   input  logic        req_hilo_mult,
   input  logic [1:0]  req_processor,
   input  logic        rsp_valid,
   input  logic [3:0]  rsp_answer,
   input  logic [9:0]  rsp_busy_units,
   input  logic [31:0] rsp_total_locked,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data,
   output int          mismatch_count,
   output int          answers_outstanding
);

   // Functional unit codes
   localparam unit_type U_RISC_ALU = 4'd0;
   localparam unit_type U_CP1_FPU  = 4'd3;
   localparam unit_type U_LS_BR    = 4'd2;
   localparam unit_type U_CP2_SUM4 = 4'd4;
   localparam unit_type U_CP2_MAD  = 4'd5;
   localparam unit_type U_CP2_BIT  = 4'd6;
   localparam unit_type U_CP2_SCAN = 4'd7;
   localparam unit_type U_CP2_SIMD = 4'd8;
   localparam unit_type U_CP2_XFER = 4'd9;

   localparam logic [4:0] GRP_RISC_LS = 5'd5;

   typedef struct packed {
      unit_type    answer;
      logic [9:0]  busy_units;
      logic [31:0] total_locked;
   } issue_answer_type;

   count_type        limit_of [3];
   count_type        issued_by [3];
   logic [9:0]       unit_busy;
   logic [31:0]      locks_total;
   issue_answer_type predicted_answers [$];
   int               errors = 0;

   function automatic unit_type home_unit(input logic [4:0] group);
      unit_type u;
      case (group)
         5'd0:                         u = U_RISC_ALU;
         5'd1, 5'd2, 5'd3, 5'd4:       u = U_CP1_FPU;
         5'd5, 5'd6, 5'd7:             u = U_LS_BR;
         5'd8:                         u = U_CP2_SUM4;
         5'd9, 5'd10:                  u = U_CP2_MAD;
         5'd11:                        u = U_CP2_BIT;
         5'd12:                        u = U_CP2_SCAN;
         5'd13:                        u = U_CP2_SIMD;
         5'd14, 5'd15, 5'd16:          u = U_CP2_XFER;
         default:                      u = SHARED_UNIT;
      endcase
      return u;
   endfunction

   task automatic resolve_command(input logic [1:0] mode, input logic [4:0] kind,
                                  input logic hilo, input logic [1:0] proc,
                                  output issue_answer_type res);
      unit_type pick;
      unit_type alt;
      unit_type ans;
      case (mode_type'(mode))
         MODE_CHECK: begin
            if (proc > PROC_CP2) begin
               ans = ANS_UNDEFINED;
            end else if (issued_by[proc] >= limit_of[proc]) begin
               ans = ANS_FULL;
            end else if (kind >= GROUP_COUNT) begin
               ans = ANS_UNDEFINED;
            end else begin
               pick = home_unit(kind);
               alt  = (kind == GROUP_RISC_ALU || kind == GRP_RISC_LS) ? SHARED_UNIT : NO_UNIT;
               // mfhi/mflo/mult can only go to the shared unit
               if (kind == GROUP_RISC_ALU && hilo) begin
                  pick = SHARED_UNIT;
                  alt  = NO_UNIT;
               end
               if (pick != NO_UNIT && !unit_busy[pick])
                  ans = pick;
               else if (alt != NO_UNIT && !unit_busy[alt])
                  ans = alt;
               else
                  ans = ANS_NOT_READY;
            end
         end
         MODE_LOCK: begin
            if (kind >= UNIT_COUNT || proc > PROC_CP2) begin
               ans = ANS_UNDEFINED;
            end else begin
               // locking a busy unit still counts the issue; limits are not applied
               unit_busy[kind] = 1'b1;
               locks_total     = locks_total + 32'd1;
               if (issued_by[proc] != COUNT_MAX)
                  issued_by[proc] = issued_by[proc] + 4'd1;
               ans = unit_type'(kind);
            end
         end
         MODE_CLEAR: begin
            unit_busy = '0;
            foreach (issued_by[p])
               issued_by[p] = '0;
            ans = ANS_CLEAR;
         end
         default: ans = ANS_UNDEFINED;
      endcase
      res.answer       = ans;
      res.busy_units   = unit_busy;
      res.total_locked = locks_total;
   endtask

   always @(posedge clock) begin
      issue_answer_type expected;
      if (reset) begin
         limit_of[PROC_CORE] = 4'd2;
         limit_of[PROC_CP1]  = 4'd1;
         limit_of[PROC_CP2]  = 4'd2;
         foreach (issued_by[p])
            issued_by[p] = '0;
         unit_busy   = '0;
         locks_total = '0;
         predicted_answers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CORE_LIMIT: limit_of[PROC_CORE] = csr_data;
               CSR_CP1_LIMIT:  limit_of[PROC_CP1]  = csr_data;
               CSR_CP2_LIMIT:  limit_of[PROC_CP2]  = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            resolve_command(req_mode, req_kind, req_hilo_mult, req_processor, expected);
            predicted_answers.push_back(expected);
         end
         if (rsp_valid) begin
            if (predicted_answers.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing pending: answer %0d busy %h locked %0d",
                        $time, rsp_answer, rsp_busy_units, rsp_total_locked);
            end else begin
               expected = predicted_answers.pop_front();
               if (rsp_answer !== expected.answer) begin
                  errors++;
                  $display("%0t: answer expected %0d actual %0d",
                           $time, expected.answer, rsp_answer);
               end
               if (rsp_busy_units !== expected.busy_units) begin
                  errors++;
                  $display("%0t: busy_units expected %h actual %h",
                           $time, expected.busy_units, rsp_busy_units);
               end
               if (rsp_total_locked !== expected.total_locked) begin
                  errors++;
                  $display("%0t: total_locked expected %0d actual %0d",
                           $time, expected.total_locked, rsp_total_locked);
               end
            end
         end
      end
      mismatch_count      <= errors;
      answers_outstanding <= predicted_answers.size();
   end

endmodule

// File: verif/issue_unit_scoreboard_core_test.sv
// Testbench top for the issue scoreboard: clock, reset, command and limit stimulus, verdict.
`timescale 1ns / 1ps

module issue_unit_scoreboard_core_test;
   import iusb_pkg::*;

   // Codes outside the package that the stimulus needs by name
   localparam logic [1:0] MODE_RESERVED  = 2'd3;
   localparam logic [1:0] PROC_UNDEFINED = 2'd3;
   localparam logic [1:0] CSR_UNUSED     = 2'd3;

   localparam logic [4:0] GRP_CP1_ALU    = 5'd2;
   localparam logic [4:0] GRP_RISC_LS    = 5'd5;
   localparam logic [4:0] GRP_CP2_SUM4   = 5'd8;
   localparam logic [4:0] GRP_CP2_LS     = 5'd16;
   localparam logic [4:0] GRP_CP3_XFER   = 5'd22;
   localparam logic [4:0] GRP_UNDEF_LOW  = 5'd23;
   localparam logic [4:0] GRP_UNDEF_TOP  = 5'd31;

   localparam logic [4:0] UNIT_RISC_ALU  = 5'd0;
   localparam logic [4:0] UNIT_SHARED    = 5'd1;
   localparam logic [4:0] UNIT_CP2_XFER  = 5'd9;
   localparam logic [4:0] UNIT_UNDEF_LOW = 5'd10;
   localparam logic [4:0] UNIT_UNDEF_MID = 5'd15;
   localparam logic [4:0] UNIT_UNDEF_TOP = 5'd31;

   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 200;
   // Idle cycles allowed with no beat anywhere; the worst legal gap is the largest
   // random command gap plus the pipeline and the drain pause.
   localparam int WATCHDOG_IDLE = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [4:0]  req_kind = '0;
   logic        req_hilo_mult = 1'b0;
   logic [1:0]  req_processor = '0;
   logic        rsp_valid;
   logic [3:0]  rsp_answer;
   logic [9:0]  rsp_busy_units;
   logic [31:0] rsp_total_locked;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   int          mismatch_count;
   int          answers_outstanding;

   int          mode_count [4];
   int          phase_sent = 0;
   int          settings_used = 0;
   int          idle_cycles = 0;
   logic        no_gap_run = 1'b0;

   always #5 clock = ~clock;

   issue_unit_scoreboard_core i_dut (.*);

   issue_unit_scoreboard_core_checker i_checker (.*);

   // Watchdog: any command, result or CSR beat counts as progress. Sampled at the
   // falling edge, where every registered output is settled.
   always @(negedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_IDLE) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("issue_unit_scoreboard_core: mismatch");
            $finish;
         end
      end
   end

   // One command beat. A random gap first, except inside a no-gap stretch; start
   // is only lowered when a gap follows, so back-to-back beats keep it high.
   task automatic send_command(input logic [1:0] mode, input logic [4:0] kind,
                               input logic hilo, input logic [1:0] proc);
      int   gap;
      logic taken;
      if ($urandom_range(0, 39) == 0)
         no_gap_run = !no_gap_run;
      gap = no_gap_run ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_mode      <= mode;
      req_kind      <= kind;
      req_hilo_mult <= hilo;
      req_processor <= proc;
      // busy is judged at the falling edge; the next rising edge takes the beat
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      mode_count[mode]++;
      phase_sent++;
   endtask

   task automatic csr_beat(input logic [1:0] index, input logic [3:0] data);
      logic taken;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic program_limits(input logic [3:0] core_limit, input logic [3:0] cp1_limit,
                                 input logic [3:0] cp2_limit, input logic touch_unused);
      csr_beat(CSR_CORE_LIMIT, core_limit);
      csr_beat(CSR_CP1_LIMIT, cp1_limit);
      csr_beat(CSR_CP2_LIMIT, cp2_limit);
      // the fourth index maps to nothing and must leave the limits alone
      if (touch_unused)
         csr_beat(CSR_UNUSED, 4'($urandom_range(0, 15)));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Wait until every predicted answer has come back, then let the pipe settle.
   task automatic drain;
      do @(negedge clock); while (answers_outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed issue cycles: a clear, then checks each optionally
   // followed by a lock from the same processor. Long cycles fill the busy
   // mask and push issue counts into saturation. One pick in ten is a noise
   // beat with any field value, including undefined modes, groups and processors.
   task automatic run_issue_traffic(input int beats);
      int         ops;
      logic [1:0] proc;
      phase_sent = 0;
      while (phase_sent < beats) begin
         if ($urandom_range(0, 9) == 0) begin
            send_command(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
         end else begin
            send_command(MODE_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
            ops = $urandom_range(1, 24);
            repeat (ops) begin
               proc = 2'($urandom_range(0, 2));
               send_command(MODE_CHECK, 5'($urandom_range(0, GROUP_COUNT - 1)),
                            1'($urandom_range(0, 1)), proc);
               if ($urandom_range(0, 9) < 6)
                  send_command(MODE_LOCK, 5'($urandom_range(0, UNIT_COUNT - 1)),
                               1'($urandom_range(0, 1)), proc);
            end
         end
      end
      start <= 1'b0;
   endtask

   initial begin
      foreach (mode_count[m])
         mode_count[m] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under the reset limits (core 2, cp1 1, cp2 2)
      send_command(MODE_CHECK, GROUP_RISC_ALU, 1'b0, PROC_UNDEFINED);   // undefined processor
      send_command(MODE_CHECK, GROUP_RISC_ALU, 1'b0, PROC_CORE);        // risc alu unit
      send_command(MODE_CHECK, GROUP_RISC_ALU, 1'b1, PROC_CORE);        // hi/lo: shared only
      send_command(MODE_CHECK, GRP_UNDEF_TOP, 1'b1, PROC_CORE);         // undefined group
      send_command(MODE_CHECK, GRP_CP3_XFER, 1'b0, PROC_CORE);          // last defined group
      send_command(MODE_LOCK, UNIT_RISC_ALU, 1'b0, PROC_CORE);
      send_command(MODE_CHECK, GROUP_RISC_ALU, 1'b0, PROC_CORE);        // falls back to shared
      send_command(MODE_LOCK, UNIT_SHARED, 1'b1, PROC_CP1);
      send_command(MODE_CHECK, GROUP_RISC_ALU, 1'b0, PROC_CORE);        // no unit ready
      send_command(MODE_CHECK, GRP_CP1_ALU, 1'b0, PROC_CP1);            // cp1 at its limit
      send_command(MODE_LOCK, UNIT_UNDEF_MID, 1'b0, PROC_CORE);         // undefined unit
      send_command(MODE_LOCK, UNIT_UNDEF_TOP, 1'b1, PROC_UNDEFINED);
      send_command(MODE_LOCK, UNIT_RISC_ALU, 1'b0, PROC_UNDEFINED);     // undefined processor
      send_command(MODE_LOCK, UNIT_RISC_ALU, 1'b0, PROC_CORE);          // relock of busy unit
      send_command(MODE_CHECK, GRP_RISC_LS, 1'b0, PROC_CORE);           // core now full
      send_command(MODE_RESERVED, GRP_UNDEF_TOP, 1'b1, PROC_UNDEFINED); // undefined mode
      send_command(MODE_CLEAR, GRP_UNDEF_TOP, 1'b1, PROC_UNDEFINED);
      send_command(MODE_CHECK, GRP_RISC_LS, 1'b1, PROC_CORE);           // hi/lo ignored here
      send_command(MODE_LOCK, UNIT_CP2_XFER, 1'b0, PROC_CP2);
      send_command(MODE_CHECK, GRP_CP2_LS, 1'b0, PROC_CP2);             // no fallback
      send_command(MODE_LOCK, UNIT_CP2_XFER, 1'b0, PROC_CP2);
      send_command(MODE_CHECK, GRP_CP2_SUM4, 1'b0, PROC_CP2);           // cp2 full
      send_command(MODE_CHECK, GRP_UNDEF_LOW, 1'b0, PROC_CORE);
      send_command(MODE_LOCK, UNIT_UNDEF_LOW, 1'b0, PROC_CP1);
      send_command(MODE_CLEAR, '0, 1'b0, PROC_CORE);
      start <= 1'b0;
      drain();

      // Random phases, each under its own set of issue limits
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       program_limits(4'd15, 4'd15, 4'd15, 1'b1);
            1:       program_limits(4'd0, 4'd0, 4'd0, 1'b0);
            2:       program_limits(4'd2, 4'd1, 4'd2, 1'b0);
            default: program_limits(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    4'($urandom_range(0, 15)), 1'b0);
         endcase
         run_issue_traffic(PHASE_BEATS);
         drain();
      end

      $display("Sent %0d checks, %0d locks, %0d clears and %0d reserved-mode commands",
               mode_count[MODE_CHECK], mode_count[MODE_LOCK], mode_count[MODE_CLEAR],
               mode_count[MODE_RESERVED]);
      $display("Issue limits programmed %0d times; %0d field mismatches",
               settings_used, mismatch_count);
      if (mismatch_count == 0)
         $display("issue_unit_scoreboard_core: match");
      else
         $display("issue_unit_scoreboard_core: mismatch");
      $finish;
   end

endmodule
